[sv/flash_page_map_allocator_defines.svh]
// Assertion macros for the page allocator.
`ifndef FLASH_PAGE_MAP_ALLOCATOR_DEFINES_SVH
`define FLASH_PAGE_MAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FPMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fpma assertion failed");
`define FPMA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fpma assertion failed");
`else
`define FPMA_ASSERT(lbl, prop)
`define FPMA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[sv/fpma_pkg.sv]
`timescale 1ns / 1ps
package fpma_pkg;

  localparam int unsigned StorageMegs    = 16;
  localparam int unsigned FlashSectors   = StorageMegs * 256;
  localparam int unsigned SecW           = $clog2(FlashSectors);
  localparam int unsigned MapDepth       = StorageMegs * 2048 - 4;
  localparam int unsigned MapAw          = $clog2(MapDepth);
  localparam int unsigned CurReserved    = 2 * StorageMegs;
  localparam int unsigned LegacyReserved = StorageMegs;
  localparam int unsigned CurFatCount    = (FlashSectors - CurReserved) * 8;
  localparam int unsigned LegacyFatCount = StorageMegs * 2048 - 4;
  localparam int unsigned CurPerMeg      = (4096 - 16) / 2;
  localparam int unsigned LegacyFirstMeg = 2044;
  localparam int unsigned LegacyPerMegW  = 11;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SYNC  = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_e;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindErase = 2'd1;
  localparam logic [1:0] KindKeep  = 2'd2;

  function automatic logic [2:0] first_free(input logic [7:0] f);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (f[i]) p = 3'(i);
    end
    return p;
  endfunction

endpackage

[sv/fpma_meg.sv]
`timescale 1ns / 1ps
module fpma_meg (
  input  logic [15:0] fat_i,
  input  logic        legacy_i,
  output logic [15:0] meg_bit_o
);

  logic [4:0]  meg;
  logic [15:0] rel;

  always_comb begin
    rel = fat_i - 16'(fpma_pkg::LegacyFirstMeg);
    meg = 5'd0;
    if (legacy_i) begin
      if (fat_i >= 16'(fpma_pkg::LegacyFirstMeg)) begin
        meg = 5'd1 + 5'(rel >> fpma_pkg::LegacyPerMegW);
      end
    end else begin
      for (int k = 1; k < 16; k++) begin
        if (fat_i >= 16'(k * fpma_pkg::CurPerMeg)) meg = meg + 5'd1;
      end
    end
    meg_bit_o = meg[4] ? 16'd0 : (16'd1 << meg[3:0]);
  end

endmodule

[sv/flash_page_map_allocator.sv]
`timescale 1ns / 1ps
// Channel   Signals                                     Direction
// request   in_valid_i / in_ready_o, mode_i,            in
//           logical_sector_i, entry_in_i
// result    out_valid_o / out_ready_i, status_o, ...    out
// config    cfg_we_i, cfg_wdata_i (legacy_format)       in
// After reset a clearing pass over all 32764 map entries zeroes the map and bitmaps; no request meanwhile.
// Sector search: one sector at a time through the bitmap memory port, up to 4096 per pass.
// Sync, load and a forced sync clear all 4096 entries of the quarantine bitmap.
// The next request is taken once the result sits in the output register.
`include "flash_page_map_allocator_defines.svh"
module flash_page_map_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] logical_sector_i,
  input  logic [15:0] entry_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [12:0] flash_sector_o,
  output logic [2:0]  page_offset_o,
  output logic [1:0]  erase_kind_o,
  output logic [7:0]  preserve_mask_o,
  output logic        sync_request_o,
  output logic [15:0] dirty_megs_o
);

  typedef enum logic [16:0] {
    S_INIT  = 17'h00001,
    S_IDLE  = 17'h00002,
    S_MRD   = 17'h00004,
    S_MCHK  = 17'h00008,
    S_ORD   = 17'h00010,
    S_OWR   = 17'h00020,
    S_SRD   = 17'h00040,
    S_SCHK  = 17'h00080,
    S_QCLR  = 17'h00100,
    S_ALLOC = 17'h00200,
    S_URD   = 17'h00400,
    S_UWR   = 17'h00800,
    S_RRD   = 17'h01000,
    S_RWR   = 17'h02000,
    S_LRD   = 17'h04000,
    S_LWR   = 17'h08000,
    S_DONE  = 17'h10000
  } state_e;

  localparam int unsigned SecW = fpma_pkg::SecW;
  localparam int unsigned MapAw = fpma_pkg::MapAw;

  state_e state_q, state_d;

  logic [15:0] map_mem [fpma_pkg::MapDepth];
  logic [7:0]  used_mem [fpma_pkg::FlashSectors];
  logic [7:0]  quar_mem [fpma_pkg::FlashSectors];

  logic             map_we, used_we, quar_we;
  logic [MapAw-1:0] map_addr;
  logic [15:0]      map_wd, map_rd_q;
  logic [SecW-1:0]  bm_addr;
  logic [7:0]       used_wd, quar_wd, used_rd_q, quar_rd_q;

  logic             legacy_q;
  logic [1:0]       mode_q;
  logic [15:0]      fat_q, entry_q, old_q, old_d;
  logic [12:0]      open_q, open_d, pos_q, pos_d;
  logic [7:0]       free_q, free_d;
  logic [15:0]      dirty_q, dirty_d;
  logic [SecW:0]    nz_q, nz_d;
  logic [MapAw-1:0] init_q, init_d;
  logic [SecW-1:0]  cnt_q, cnt_d;
  logic             attempt_q, attempt_d, part_q, part_d;
  logic [SecW-1:0]  part_s_q, part_s_d;
  logic [7:0]       part_occ_q, part_occ_d;

  logic [1:0]  r_status_q, r_status_d, r_kind_q, r_kind_d;
  logic [12:0] r_sec_q, r_sec_d;
  logic [2:0]  r_page_q, r_page_d;
  logic [7:0]  r_mask_q, r_mask_d;
  logic        r_sync_q, r_sync_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_dirty_q, out_dirty_d;
  logic [1:0]  out_status_q, out_status_d, out_kind_q, out_kind_d;
  logic [12:0] out_sec_q, out_sec_d;
  logic [2:0]  out_page_q, out_page_d;
  logic [7:0]  out_mask_q, out_mask_d;
  logic        out_sync_q, out_sync_d;

  logic        accept, in_range, old_ok, is_rsv;
  logic [7:0]  obit, occ, pbit;
  logic [2:0]  p;
  logic [SecW-1:0] s_cur, os;
  logic [15:0] meg_bit;
  logic [SecW:0]  rsv_cnt;

  fpma_meg u_meg (
    .fat_i     (fat_q),
    .legacy_i  (legacy_q),
    .meg_bit_o (meg_bit)
  );

  function automatic logic [SecW:0] nz_adj(input logic [SecW:0] c, input logic [7:0] qo,
                                           input logic [7:0] qn);
    logic [SecW:0] r;
    r = c;
    if (qo != 8'd0 && qn == 8'd0) r = r - 1'b1;
    if (qo == 8'd0 && qn != 8'd0) r = r + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_addr] <= map_wd;
    map_rd_q <= map_mem[map_addr];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[bm_addr] <= used_wd;
    used_rd_q <= used_mem[bm_addr];
  end

  always_ff @(posedge clk_i) begin
    if (quar_we) quar_mem[bm_addr] <= quar_wd;
    quar_rd_q <= quar_mem[bm_addr];
  end

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_range = logical_sector_i < (legacy_q ?
                    16'(fpma_pkg::LegacyFatCount) : 16'(fpma_pkg::CurFatCount));
  assign old_ok = (old_q != 16'd0) && !old_q[15];
  assign os = old_q[SecW+2:3];
  assign obit = 8'd1 << old_q[2:0];
  assign s_cur = pos_q[SecW-1:0] + cnt_q;
  assign rsv_cnt = legacy_q ? (SecW+1)'(fpma_pkg::LegacyReserved) :
                              (SecW+1)'(fpma_pkg::CurReserved);
  assign is_rsv = {1'b0, s_cur} < rsv_cnt;
  assign occ = is_rsv ? 8'hFF : (used_rd_q | quar_rd_q);
  assign p = fpma_pkg::first_free(free_q);
  assign pbit = 8'd1 << p;

  always_comb begin
    state_d = state_q;
    map_we = 1'b0; map_addr = fat_q[MapAw-1:0]; map_wd = 16'd0;
    used_we = 1'b0; used_wd = 8'd0; quar_we = 1'b0; quar_wd = 8'd0;
    bm_addr = s_cur;
    old_d = old_q; open_d = open_q; pos_d = pos_q; free_d = free_q;
    dirty_d = dirty_q; nz_d = nz_q; init_d = init_q; cnt_d = cnt_q;
    attempt_d = attempt_q; part_d = part_q; part_s_d = part_s_q; part_occ_d = part_occ_q;
    r_status_d = r_status_q; r_kind_d = r_kind_q; r_sec_d = r_sec_q;
    r_page_d = r_page_q; r_mask_d = r_mask_q; r_sync_d = r_sync_q;
    out_valid_d = out_valid_q && !out_ready_i; out_dirty_d = out_dirty_q;
    out_status_d = out_status_q; out_kind_d = out_kind_q; out_sec_d = out_sec_q;
    out_page_d = out_page_q; out_mask_d = out_mask_q; out_sync_d = out_sync_q;

    case (state_q)
      S_INIT: begin
        map_we = 1'b1; map_addr = init_q;
        bm_addr = init_q[SecW-1:0];
        used_we = (init_q < MapAw'(fpma_pkg::FlashSectors));
        quar_we = used_we;
        init_d = init_q + 1'b1;
        if (init_q == MapAw'(fpma_pkg::MapDepth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          r_status_d = fpma_pkg::StOk; r_kind_d = fpma_pkg::KindNone;
          r_sec_d = 13'd0; r_page_d = 3'd0; r_mask_d = 8'd0; r_sync_d = 1'b0;
          cnt_d = '0;
          if (mode_i == fpma_pkg::MODE_SYNC) begin
            dirty_d = 16'd0;
            state_d = S_QCLR;
          end else if (!in_range) begin
            r_status_d = fpma_pkg::StRange;
            state_d = S_DONE;
          end else if (mode_i == fpma_pkg::MODE_LOAD) begin
            state_d = S_LRD;
          end else begin
            state_d = S_MRD;
          end
        end
      end
      S_MRD: state_d = S_MCHK;
      S_MCHK: begin
        if (mode_q == fpma_pkg::MODE_READ) begin
          r_sec_d = map_rd_q[15:3];
          r_page_d = map_rd_q[2:0];
          state_d = S_DONE;
        end else begin
          old_d = map_rd_q;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        bm_addr = os;
        state_d = S_OWR;
      end
      S_OWR: begin
        bm_addr = os;
        if (old_ok) begin
          used_we = 1'b1; used_wd = used_rd_q & ~obit;
          quar_we = 1'b1; quar_wd = quar_rd_q | obit;
          nz_d = nz_adj(nz_q, quar_rd_q, quar_rd_q | obit);
        end
        if (open_q == 13'd0 || free_q == 8'd0) begin
          cnt_d = '0; attempt_d = 1'b0; part_d = 1'b0;
          state_d = S_SRD;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_SRD: state_d = S_SCHK;
      S_SCHK: begin
        cnt_d = cnt_q + 1'b1;
        state_d = S_SRD;
        if (occ != 8'hFF && !part_q) begin
          part_d = 1'b1; part_s_d = s_cur; part_occ_d = occ;
        end
        if (occ == 8'd0) begin
          open_d = 13'(s_cur); pos_d = 13'(s_cur); free_d = 8'hFF;
          r_kind_d = fpma_pkg::KindErase; r_mask_d = 8'd0;
          state_d = S_ALLOC;
        end else if (cnt_q == '1) begin
          if (part_q || occ != 8'hFF) begin
            open_d = 13'(part_q ? part_s_q : s_cur);
            pos_d = open_d;
            free_d = ~(part_q ? part_occ_q : occ);
            r_kind_d = fpma_pkg::KindKeep;
            r_mask_d = part_q ? part_occ_q : occ;
            state_d = S_ALLOC;
          end else if (!attempt_q && nz_q != '0) begin
            attempt_d = 1'b1; r_sync_d = 1'b1; dirty_d = 16'd0;
            cnt_d = '0;
            state_d = S_QCLR;
          end else begin
            r_status_d = fpma_pkg::StFull; r_kind_d = fpma_pkg::KindNone; r_mask_d = 8'd0;
            state_d = old_ok ? S_RRD : S_DONE;
          end
        end
      end
      S_QCLR: begin
        bm_addr = cnt_q;
        quar_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          nz_d = '0;
          if (mode_q == fpma_pkg::MODE_WRITE) begin
            part_d = 1'b0;
            state_d = S_SRD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        map_we = 1'b1;
        map_wd = {open_q, p};
        free_d = free_q & ~pbit;
        dirty_d = dirty_q | meg_bit;
        r_sec_d = open_q; r_page_d = p;
        state_d = S_URD;
      end
      S_URD: begin
        bm_addr = open_q[SecW-1:0];
        state_d = S_UWR;
      end
      S_UWR: begin
        bm_addr = open_q[SecW-1:0];
        used_we = 1'b1; used_wd = used_rd_q | (8'd1 << r_page_q);
        state_d = S_DONE;
      end
      S_RRD: begin
        bm_addr = os;
        state_d = S_RWR;
      end
      S_RWR: begin
        bm_addr = os;
        used_we = 1'b1; used_wd = used_rd_q | obit;
        quar_we = 1'b1; quar_wd = quar_rd_q & ~obit;
        nz_d = nz_adj(nz_q, quar_rd_q, quar_rd_q & ~obit);
        state_d = S_DONE;
      end
      S_LRD: begin
        map_we = 1'b1; map_wd = entry_q;
        bm_addr = entry_q[SecW+2:3];
        state_d = S_LWR;
      end
      S_LWR: begin
        bm_addr = entry_q[SecW+2:3];
        used_we = (entry_q != 16'd0) && !entry_q[15];
        used_wd = used_rd_q | (8'd1 << entry_q[2:0]);
        open_d = 13'd0; dirty_d = 16'd0;
        cnt_d = '0;
        state_d = S_QCLR;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_dirty_d = dirty_q;
          out_status_d = r_status_q; out_kind_d = r_kind_q; out_sec_d = r_sec_q;
          out_page_d = r_page_q; out_mask_d = r_mask_q; out_sync_d = r_sync_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      legacy_q <= 1'b0;
      open_q <= 13'd0; pos_q <= 13'd0; free_q <= 8'd0;
      dirty_q <= 16'd0; nz_q <= '0; init_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) legacy_q <= cfg_wdata_i;
      open_q <= open_d; pos_q <= pos_d; free_q <= free_d;
      dirty_q <= dirty_d; nz_q <= nz_d; init_q <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; fat_q <= logical_sector_i; entry_q <= entry_in_i;
    end
    old_q <= old_d; cnt_q <= cnt_d;
    attempt_q <= attempt_d; part_q <= part_d; part_s_q <= part_s_d; part_occ_q <= part_occ_d;
    r_status_q <= r_status_d; r_kind_q <= r_kind_d; r_sec_q <= r_sec_d;
    r_page_q <= r_page_d; r_mask_q <= r_mask_d; r_sync_q <= r_sync_d;
    out_dirty_q <= out_dirty_d;
    out_status_q <= out_status_d; out_kind_q <= out_kind_d; out_sec_q <= out_sec_d;
    out_page_q <= out_page_d; out_mask_q <= out_mask_d; out_sync_q <= out_sync_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign flash_sector_o  = out_sec_q;
  assign page_offset_o   = out_page_q;
  assign erase_kind_o    = out_kind_q;
  assign preserve_mask_o = out_mask_q;
  assign sync_request_o  = out_sync_q;
  assign dirty_megs_o    = out_dirty_q;

  `FPMA_ASSERT(a_fail_no_erase, out_valid_o && status_o != fpma_pkg::StOk |-> erase_kind_o == fpma_pkg::KindNone)
  `FPMA_ASSERT(a_mask_keep_only, out_valid_o && erase_kind_o != fpma_pkg::KindKeep |-> preserve_mask_o == 8'd0)
  `FPMA_ASSERT_NEXT(a_qclr_zero, state_q == S_QCLR && cnt_q == '1, nz_q == '0)
  `FPMA_ASSERT(a_init_busy, state_q == S_INIT |-> !in_ready_o)

endmodule
